/* hdl/sha256_pkg.sv */
package sha256_pkg;

   // Number of rounds in one compression and bytes in one message block.
   localparam int unsigned NumRounds  = 64;
   localparam int unsigned BlockBytes = 64;

   // Byte position at which the 64-bit length field starts.
   localparam logic [5:0] LenFieldStart = 6'd56;

   // First padding byte after the message.
   localparam logic [7:0] PadMarker = 8'h80;

   typedef logic [31:0] word_type;

   // Right rotation by a constant amount.
   function automatic word_type rotr(input word_type v, input int unsigned n);
      rotr = (v >> n) | (v << (32 - n));
   endfunction

   function automatic word_type sum_e(input word_type v);
      sum_e = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
   endfunction

   function automatic word_type sum_a(input word_type v);
      sum_a = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
   endfunction

   function automatic word_type mix_lo(input word_type v);
      mix_lo = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
   endfunction

   function automatic word_type mix_hi(input word_type v);
      mix_hi = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
   endfunction

   // Initial hash value, word 0 first.
   function automatic word_type initial_hash(input logic [2:0] idx);
      case (idx)
         3'd0:    initial_hash = 32'h6a09e667;
         3'd1:    initial_hash = 32'hbb67ae85;
         3'd2:    initial_hash = 32'h3c6ef372;
         3'd3:    initial_hash = 32'ha54ff53a;
         3'd4:    initial_hash = 32'h510e527f;
         3'd5:    initial_hash = 32'h9b05688c;
         3'd6:    initial_hash = 32'h1f83d9ab;
         default: initial_hash = 32'h5be0cd19;
      endcase
   endfunction

   // Round constants.
   function automatic word_type round_k(input logic [5:0] idx);
      case (idx)
         6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
         6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
         6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
         6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
         6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
         6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
         6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
         6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
         6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
         6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
         6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
         6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
         6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
         6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
         6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
         6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
         6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
         6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
         6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
         6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
         6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
         6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
         6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
         6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
         6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
         6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
         6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
         6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
         6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
         6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
         6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
         6'd62: round_k = 32'hbef9a3f7;  6'd63: round_k = 32'hc67178f2;
         default: round_k = 32'h00000000;
      endcase
   endfunction

endpackage

/* hdl/sha256_message_digest_unit.sv */
// SHA-256 digest engine. The message arrives as big-endian 32-bit words with a byte count
// and a final flag; the block stalls its input while it works and takes one item at a time.
// Bytes go into the 64-byte block buffer one per cycle while no compression is running.
// Each time the buffer fills, the single round unit runs 64 rounds and then updates the
// chaining value. The final item adds 9 to 72 padding bytes at one per cycle in the same
// way, one or two compressions, and then eight digest words, one per output transfer,
// word 0 first and the last one marked. After the last digest word the block is ready
// for a new message; no clearing pass follows reset.
module sha256_message_digest_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_byte_count,
   input  logic        req_final_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_of_digest
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_BYTES,
      S_PAD,
      S_ROUND,
      S_UPDATE,
      S_OUT
   } state_type;

   state_type state_ff, state_in, after_state;

   logic [31:0] chain_ff [8];
   logic [31:0] chain_in [8];
   logic [31:0] work_ff  [8];
   logic [31:0] work_in  [8];
   logic [31:0] win_ff   [16];
   logic [31:0] win_in   [16];

   logic [63:0] len_ff, len_in;
   logic [5:0]  fill_ff, fill_in;
   logic [5:0]  round_ff, round_in;
   logic [31:0] word_ff, word_in;
   logic [2:0]  left_ff, left_in;
   logic        final_ff, final_in;
   logic        mark_ff, mark_in;
   logic        lenph_ff, lenph_in;
   logic        lendone_ff, lendone_in;
   logic [2:0]  oidx_ff, oidx_in;

   logic        push_en;
   logic [7:0]  push_byte;
   logic [31:0] sched_w, t1, t2, ch, maj;
   logic [5:0]  len_shift;
   logic [4:0]  lane_shift;

   // Round datapath: message schedule word and the two temporaries.
   always_comb begin
      if (round_ff < 6'd16) begin
         sched_w = win_ff[0];
      end else begin
         sched_w = sha256_pkg::mix_hi(win_ff[14]) + win_ff[9]
                 + sha256_pkg::mix_lo(win_ff[1]) + win_ff[0];
      end
      ch  = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
      maj = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2]) ^ (work_ff[1] & work_ff[2]);
      t1  = work_ff[7] + sha256_pkg::sum_e(work_ff[4]) + ch
          + sha256_pkg::round_k(round_ff) + sched_w;
      t2  = sha256_pkg::sum_a(work_ff[0]) + maj;
   end

   // Byte position of the length field and lane of the next buffer byte.
   assign len_shift  = {~fill_ff[2:0], 3'b000};
   assign lane_shift = {~fill_ff[1:0], 3'b000};

   // Sequencer and next-state logic.
   always_comb begin
      state_in    = state_ff;
      after_state = state_ff;
      chain_in    = chain_ff;
      work_in     = work_ff;
      win_in      = win_ff;
      len_in      = len_ff;
      fill_in     = fill_ff;
      round_in    = round_ff;
      word_in     = word_ff;
      left_in     = left_ff;
      final_in    = final_ff;
      mark_in     = mark_ff;
      lenph_in    = lenph_ff;
      lendone_in  = lendone_ff;
      oidx_in     = oidx_ff;
      push_en     = 1'b0;
      push_byte   = 8'h00;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               word_in    = req_data_word;
               left_in    = (req_byte_count > 3'd4) ? 3'd4 : req_byte_count;
               final_in   = req_final_word;
               mark_in    = 1'b0;
               lenph_in   = 1'b0;
               lendone_in = 1'b0;
               if (req_byte_count != 3'd0) begin
                  state_in = S_BYTES;
               end else if (req_final_word) begin
                  state_in = S_PAD;
               end
            end
         end
         S_BYTES: begin
            push_en   = 1'b1;
            push_byte = word_ff[31:24];
            word_in   = word_ff << 8;
            left_in   = left_ff - 3'd1;
            len_in    = len_ff + 64'd8;
            if (left_ff != 3'd1) begin
               after_state = S_BYTES;
            end else if (final_ff) begin
               after_state = S_PAD;
            end else begin
               after_state = S_IDLE;
            end
         end
         S_PAD: begin
            push_en     = 1'b1;
            after_state = S_PAD;
            if (!mark_ff) begin
               push_byte = sha256_pkg::PadMarker;
               mark_in   = 1'b1;
            end else if (lenph_ff || fill_ff == sha256_pkg::LenFieldStart) begin
               push_byte = len_ff[len_shift +: 8];
               lenph_in  = 1'b1;
               if (fill_ff == 6'(sha256_pkg::BlockBytes - 1)) begin
                  lendone_in = 1'b1;
               end
            end
         end
         S_ROUND: begin
            // One round; the schedule window shifts by one word.
            for (int i = 0; i < 15; i++) begin
               win_in[i] = win_ff[i + 1];
            end
            win_in[15] = sched_w;
            work_in[7] = work_ff[6];
            work_in[6] = work_ff[5];
            work_in[5] = work_ff[4];
            work_in[4] = work_ff[3] + t1;
            work_in[3] = work_ff[2];
            work_in[2] = work_ff[1];
            work_in[1] = work_ff[0];
            work_in[0] = t1 + t2;
            round_in   = round_ff + 6'd1;
            if (round_ff == 6'(sha256_pkg::NumRounds - 1)) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            for (int i = 0; i < 8; i++) begin
               chain_in[i] = chain_ff[i] + work_ff[i];
            end
            if (lendone_ff) begin
               state_in = S_OUT;
               oidx_in  = 3'd0;
            end else if (left_ff != 3'd0) begin
               state_in = S_BYTES;
            end else if (final_ff) begin
               state_in = S_PAD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_OUT: begin
            if (!rsp_stall) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == 3'd7) begin
                  for (int i = 0; i < 8; i++) begin
                     chain_in[i] = sha256_pkg::initial_hash(3'(i));
                  end
                  len_in     = 64'd0;
                  fill_in    = 6'd0;
                  final_in   = 1'b0;
                  lendone_in = 1'b0;
                  state_in   = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Shared byte insertion into the block buffer; a full buffer starts a compression.
      if (push_en) begin
         win_in[fill_ff[5:2]][lane_shift +: 8] = push_byte;
         if (fill_ff == 6'(sha256_pkg::BlockBytes - 1)) begin
            fill_in  = 6'd0;
            round_in = 6'd0;
            work_in  = chain_ff;
            state_in = S_ROUND;
         end else begin
            fill_in  = fill_ff + 6'd1;
            state_in = after_state;
         end
      end
   end

   // State, control and datapath registers.
   always_ff @(posedge clock) begin
      work_ff <= work_in;
      win_ff  <= win_in;
      word_ff <= word_in;
      if (reset) begin
         state_ff   <= S_IDLE;
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= sha256_pkg::initial_hash(3'(i));
         end
         len_ff     <= 64'd0;
         fill_ff    <= 6'd0;
         round_ff   <= 6'd0;
         left_ff    <= 3'd0;
         final_ff   <= 1'b0;
         mark_ff    <= 1'b0;
         lenph_ff   <= 1'b0;
         lendone_ff <= 1'b0;
         oidx_ff    <= 3'd0;
      end else begin
         state_ff   <= state_in;
         chain_ff   <= chain_in;
         len_ff     <= len_in;
         fill_ff    <= fill_in;
         round_ff   <= round_in;
         left_ff    <= left_in;
         final_ff   <= final_in;
         mark_ff    <= mark_in;
         lenph_ff   <= lenph_in;
         lendone_ff <= lendone_in;
         oidx_ff    <= oidx_in;
      end
   end

   // Handshake and digest outputs, all taken from registers.
   assign req_stall          = (state_ff != S_IDLE);
   assign rsp_valid          = (state_ff == S_OUT);
   assign rsp_digest_word    = chain_ff[oidx_ff];
   assign rsp_word_index     = oidx_ff;
   assign rsp_last_of_digest = (oidx_ff == 3'd7);

endmodule

/* hdl/sha256_chk.sv */
module sha256_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_digest_word,
   input logic [2:0]  rsp_word_index,
   input logic        rsp_last_of_digest
);

   // A stalled digest word holds until its transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_digest_word)
                                 && $stable(rsp_word_index))
      else $error("digest word changed while stalled");

   // The input side is closed while digest words go out.
   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open during digest output");

   // Digest words follow in order without gaps.
   a_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_of_digest |=>
         rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1)
      else $error("digest word sequence broken");

   // The last mark sits on word seven only.
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_of_digest == (rsp_word_index == 3'd7)))
      else $error("last mark on the wrong word");

endmodule

bind sha256_message_digest_unit sha256_chk u_sha256_chk (.*);

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

   localparam int TailItems = 24;
   localparam int MaxReported = 10;

   // Round constants and initial hash words, first entry in the top bits.
   localparam logic [2047:0] RoundK = {
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };
   localparam logic [255:0] StartHash = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   typedef sha256_pkg::word_type word_type;

   typedef struct packed {
      word_type   data_word;
      logic [2:0] byte_count;
      logic       is_final;
   } message_item_type;

   typedef struct packed {
      word_type   value;
      logic [2:0] index;
      logic       is_last;
   } digest_out_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_data_word = 32'd0;
   logic [2:0]  req_byte_count = 3'd0;
   logic        req_final_word = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_of_digest;

   sha256_message_digest_unit uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_word      (req_data_word),
      .req_byte_count     (req_byte_count),
      .req_final_word     (req_final_word),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_digest_word    (rsp_digest_word),
      .rsp_word_index     (rsp_word_index),
      .rsp_last_of_digest (rsp_last_of_digest)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   message_item_type pending_items[$];
   digest_out_type   expected_digest[$];

   // Digest state of the running message.
   word_type    hash_state [8];
   word_type    block_words [16];
   logic [63:0] message_bits;
   int          block_fill;

   int error_count = 0;
   int items_accepted = 0;
   int words_checked = 0;
   int digests_checked = 0;

   function automatic word_type ror(input word_type v, input int n);
      return (v >> n) | (v << (32 - n));
   endfunction

   function automatic word_type rot_sum_a(input word_type v);
      return ror(v, 2) ^ ror(v, 13) ^ ror(v, 22);
   endfunction

   function automatic word_type rot_sum_e(input word_type v);
      return ror(v, 6) ^ ror(v, 11) ^ ror(v, 25);
   endfunction

   function automatic word_type sched_mix_lo(input word_type v);
      return ror(v, 7) ^ ror(v, 18) ^ (v >> 3);
   endfunction

   function automatic word_type sched_mix_hi(input word_type v);
      return ror(v, 17) ^ ror(v, 19) ^ (v >> 10);
   endfunction

   task automatic restart_message();
      int i;
      for (i = 0; i < 8; i++) begin
         hash_state[i] = StartHash[255 - 32 * i -: 32];
      end
      message_bits = 64'd0;
      block_fill = 0;
   endtask

   // One full compression of the block buffer into the hash state; the
   // message schedule is expanded in place over the 16-word window.
   task automatic compress_buffer();
      word_type a, b, c, d, e, f, g, h, w, t1, t2;
      int r;
      a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
      e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
      for (r = 0; r < sha256_pkg::NumRounds; r++) begin
         if (r < 16) begin
            w = block_words[r];
         end else begin
            w = sched_mix_hi(block_words[(r - 2) % 16]) + block_words[(r - 7) % 16]
              + sched_mix_lo(block_words[(r - 15) % 16]) + block_words[r % 16];
            block_words[r % 16] = w;
         end
         t1 = h + rot_sum_e(e) + ((e & f) ^ (~e & g)) + RoundK[2047 - 32 * r -: 32] + w;
         t2 = rot_sum_a(a) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
      hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
   endtask

   // Bytes fill the buffer big-endian within each word.
   task automatic append_byte(input logic [7:0] value);
      int slot;
      int shift;
      slot = block_fill / 4;
      shift = 24 - 8 * (block_fill % 4);
      block_words[slot] = (block_words[slot] & ~(32'hff << shift)) | ({24'd0, value} << shift);
      block_fill++;
      if (block_fill == sha256_pkg::BlockBytes) begin
         compress_buffer();
         block_fill = 0;
      end
   endtask

   // Take one accepted item; a final item pads the message and yields the digest.
   task automatic absorb_item(input message_item_type item);
      int n;
      int k;
      logic [63:0] length_bits;
      logic [7:0] next_byte;
      digest_out_type out_word;
      n = (item.byte_count > 3'd4) ? 4 : item.byte_count;
      for (k = 0; k < n; k++) begin
         next_byte = item.data_word[31 - 8 * k -: 8];
         append_byte(next_byte);
         message_bits += 64'd8;
      end
      if (item.is_final) begin
         length_bits = message_bits;
         append_byte(sha256_pkg::PadMarker);
         while (block_fill != sha256_pkg::LenFieldStart) begin
            append_byte(8'h00);
         end
         for (k = 7; k >= 0; k--) begin
            next_byte = length_bits[8 * k +: 8];
            append_byte(next_byte);
         end
         for (k = 0; k < 8; k++) begin
            out_word.value = hash_state[k];
            out_word.index = k[2:0];
            out_word.is_last = (k == 7);
            expected_digest = {expected_digest, out_word};
         end
         restart_message();
      end
   endtask

   function automatic void report_error(input string text);
      error_count++;
      if (error_count <= MaxReported) begin
         $display("%0t: %s", $realtime, text);
      end
   endfunction

   task automatic queue_item(input word_type data, input int count, input bit last);
      message_item_type item;
      item.data_word = data;
      item.byte_count = count[2:0];
      item.is_final = last;
      pending_items = {pending_items, item};
   endtask

   // Mostly clean messages of full words; some carry odd counts and empty items.
   task automatic queue_random_message();
      int n_words;
      int shape;
      int i;
      bit noisy;
      noisy = ($urandom_range(0, 9) >= 7);
      shape = $urandom_range(0, 5);
      if (shape < 2) begin
         n_words = $urandom_range(12, 17);
      end else if (shape == 2) begin
         n_words = $urandom_range(28, 33);
      end else begin
         n_words = $urandom_range(0, 10);
      end
      for (i = 0; i < n_words; i++) begin
         queue_item($urandom, noisy ? $urandom_range(0, 7) : 4, 1'b0);
      end
      queue_item($urandom, noisy ? $urandom_range(0, 7) : $urandom_range(0, 4), 1'b1);
   endtask

   // Request driver: presents queued items with random idle bursts.
   int send_gap = 0;
   int send_calm = 0;
   message_item_type presented_item;

   always @(posedge clock) begin : drive_requests
      int pick;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            absorb_item(presented_item);
            items_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (send_calm > 0) begin
               send_calm--;
            end else if (send_gap == 0 && pending_items.size() >= TailItems) begin
               pick = $urandom_range(0, 7);
               if (pick < 2) begin
                  send_gap = $urandom_range(1, 13);
               end else if (pick == 2) begin
                  send_calm = $urandom_range(10, 80);
               end
            end
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               presented_item = pending_items.pop_front();
               req_data_word <= presented_item.data_word;
               req_byte_count <= presented_item.byte_count;
               req_final_word <= presented_item.is_final;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Digest monitor: checks each transfer against the oldest expected word
   // and stalls the result channel in random bursts.
   int hold_gap = 0;
   int hold_calm = 0;

   always @(posedge clock) begin : watch_digest
      digest_out_type want;
      int pick;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_digest.size() == 0) begin
               report_error($sformatf("unexpected digest word %h index %0d last %0b",
                  rsp_digest_word, rsp_word_index, rsp_last_of_digest));
            end else begin
               want = expected_digest.pop_front();
               if (rsp_digest_word !== want.value || rsp_word_index !== want.index ||
                   rsp_last_of_digest !== want.is_last) begin
                  report_error($sformatf(
                     "digest mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                     want.value, want.index, want.is_last,
                     rsp_digest_word, rsp_word_index, rsp_last_of_digest));
               end
               words_checked++;
               if (want.is_last) begin
                  digests_checked++;
               end
            end
         end
         if (hold_calm > 0) begin
            hold_calm--;
         end else if (hold_gap == 0 && pending_items.size() >= TailItems) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
               hold_gap = $urandom_range(1, 13);
            end else if (pick == 1) begin
               hold_calm = $urandom_range(10, 80);
            end
         end
         if (hold_gap > 0) begin
            hold_gap--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Stimulus, then drain and verdict.
   initial begin : run_sequence
      int i;
      restart_message();
      for (i = 0; i < 16; i++) begin
         block_words[i] = 32'd0;
      end

      // Empty message, with junk in the unused bytes.
      queue_item(32'hffffffff, 0, 1'b1);
      // Three-byte message "abc".
      queue_item(32'h61626300, 3, 1'b1);
      // Oversized counts, an empty non-final item, partial non-final words.
      queue_item(32'hffffffff, 5, 1'b0);
      queue_item(32'h00000000, 6, 1'b0);
      queue_item(32'ha5a5a5a5, 0, 1'b0);
      queue_item(32'hffffffff, 2, 1'b0);
      queue_item(32'h12345678, 1, 1'b0);
      queue_item(32'h80000001, 7, 1'b1);
      // Short message ending in a single byte with all-ones data.
      queue_item(32'h00000000, 4, 1'b0);
      queue_item(32'hffffffff, 1, 1'b1);
      // 55 bytes: the longest message whose padding fits in one block.
      for (i = 0; i < 13; i++) begin
         queue_item($urandom, 4, 1'b0);
      end
      queue_item($urandom, 3, 1'b1);

      while (pending_items.size() < 224) begin
         queue_random_message();
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || req_valid) begin
         @(posedge clock);
      end
      while (expected_digest.size() != 0) begin
         @(posedge clock);
      end
      repeat (100) @(posedge clock);

      $display("Hashed %0d message items into %0d digests; %0d digest words compared.",
         items_accepted, digests_checked, words_checked);
      $display("Errors found: %0d", error_count);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog far beyond the slowest legal run.
   initial begin : watchdog
      #2000000;
      $display("Timed out with %0d items queued and %0d digest words outstanding.",
         pending_items.size(), expected_digest.size());
      $display("CHECK FAILED");
      $finish;
   end

endmodule
